### src/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and constants for the sorted timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package stq_pkg;

	localparam int SLOTS_DEF     = 16;
	localparam int TIME_BITS_DEF = 32;
	localparam int MAX_OUT       = 16;
	localparam int KCNT_W        = $clog2(MAX_OUT + 1);

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_ARM  = 2'd1,
		CMD_STOP = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		LOP_NONE,
		LOP_POP,
		LOP_DROP,
		LOP_INSERT
	} list_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK,
		ST_DROP,
		ST_SCAN,
		ST_ACK
	} state_t;

endpackage

`default_nettype wire

### src/stq_cmp.sv
// ----------------------------------------------------------------------------
// stq_cmp
// Shared wrap-safe time compare: later is set when a is strictly after b.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_cmp #(
	parameter int TIME_BITS = stq_pkg::TIME_BITS_DEF
) (
	input  wire logic [TIME_BITS-1:0] a,
	input  wire logic [TIME_BITS-1:0] b,
	output logic                      later
);

	logic [TIME_BITS-1:0] diff;

	assign diff  = a - b;
	assign later = (diff != '0) && !diff[TIME_BITS-1];

endmodule

`default_nettype wire

### src/stq_list.sv
// ----------------------------------------------------------------------------
// stq_list
// Ordered list of slot numbers with pop, drop-by-id and insert-at-position.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_list #(
	parameter int SLOTS = stq_pkg::SLOTS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire stq_pkg::list_op_t            op,
	input  wire logic [$clog2(SLOTS)-1:0]     id,
	input  wire logic [$clog2(SLOTS+1)-1:0]   pos,
	output logic [$clog2(SLOTS)-1:0]          head,
	output logic [$clog2(SLOTS)-1:0]          at_pos,
	output logic [$clog2(SLOTS+1)-1:0]        cnt
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	logic [IW-1:0] ord_q [SLOTS];
	logic [IW-1:0] ord_d [SLOTS];
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_d;
	logic [SLOTS-1:0] hit_pre;

	assign head   = ord_q[0];
	assign at_pos = ord_q[pos[IW-1:0]];
	assign cnt    = cnt_q;

	always_comb begin
		hit_pre[0] = (ord_q[0] == id) && (cnt_q != '0);
		for (int i = 1; i < SLOTS; i++) begin
			hit_pre[i] = hit_pre[i-1] || ((ord_q[i] == id) && (CW'(i) < cnt_q));
		end
	end

	always_comb begin
		cnt_d = cnt_q;
		for (int i = 0; i < SLOTS; i++) begin
			ord_d[i] = ord_q[i];
		end
		case (op)
			stq_pkg::LOP_POP: begin
				for (int i = 0; i < SLOTS - 1; i++) begin
					ord_d[i] = ord_q[i+1];
				end
				cnt_d = cnt_q - 1'b1;
			end
			stq_pkg::LOP_DROP: begin
				for (int i = 0; i < SLOTS - 1; i++) begin
					if (hit_pre[i]) begin
						ord_d[i] = ord_q[i+1];
					end
				end
				if (hit_pre[SLOTS-1]) begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			stq_pkg::LOP_INSERT: begin
				for (int i = 1; i < SLOTS; i++) begin
					if (CW'(i) > pos) begin
						ord_d[i] = ord_q[i-1];
					end
				end
				ord_d[pos[IW-1:0]] = id;
				cnt_d = cnt_q + 1'b1;
			end
			default: begin
				cnt_d = cnt_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < SLOTS; i++) begin
			ord_q[i] <= ord_d[i];
		end
	end

endmodule

`default_nettype wire

### src/sorted_timer_queue.sv
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Timer slots kept in expiry order with a running tick count.
// ----------------------------------------------------------------------------
// One command is taken at a time. A stop passes through the drop and
// acknowledge states; an arm also passes through a scan state, where the
// insertion point is found by walking the list one entry per cycle through
// the single time comparator. A tick pops expired entries from the head,
// each head test going through the same comparator. Results wait in an
// output register while the master is stalled.
`default_nettype none

module sorted_timer_queue #(
	parameter int SLOTS     = stq_pkg::SLOTS_DEF,
	parameter int TIME_BITS = stq_pkg::TIME_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [79:0] s_axis_tdata,  // timer_id, delay, handler, payload
	input  wire logic [1:0]  s_axis_tuser,  // cmd
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata,  // head_changed, expired_id, handler, payload
	output logic             m_axis_tuser,  // kind
	output logic             m_axis_tlast   // last
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int SW = ((TIME_BITS > 31) ? TIME_BITS : 31) + 1;
	localparam int KW = stq_pkg::KCNT_W;

	stq_pkg::state_t state_q, state_d;
	stq_pkg::list_op_t lop;
	stq_pkg::cmd_t in_cmd;

	logic [3:0]  in_id;
	logic [30:0] in_delay;
	logic [7:0]  in_handler;
	logic [31:0] in_payload;
	logic        in_acc;
	logic        in_range;
	logic [IW-1:0] in_slot;

	logic [TIME_BITS-1:0] tick_q;
	logic [TIME_BITS-1:0] t_q;
	logic [SW-1:0]        t_sum;
	logic [TIME_BITS-1:0] expiry_q [SLOTS];
	logic [7:0]           handler_q [SLOTS];
	logic [31:0]          payload_q [SLOTS];
	logic [SLOTS-1:0]     pending_q;

	logic [IW-1:0] slot_q;
	logic          arm_q;
	logic          was_head_q;
	logic          hc_q;
	logic [CW-1:0] pos_q;
	logic [KW-1:0] k_q;

	logic          hold_v_q;
	logic [IW-1:0] hold_id_q;
	logic [7:0]    hold_handler_q;
	logic [31:0]   hold_payload_q;

	logic [IW-1:0] head, at_pos, rd_idx;
	logic [CW-1:0] cnt;
	logic [TIME_BITS-1:0] cmp_b;
	logic          later;
	logic          due;
	logic          out_free;
	logic          out_load;

	logic          out_v_q;
	logic          out_kind_q, out_hc_q, out_last_q;
	logic [3:0]    out_id_q;
	logic [7:0]    out_handler_q;
	logic [31:0]   out_payload_q;

	assign in_cmd     = stq_pkg::cmd_t'(s_axis_tuser);
	assign in_id      = s_axis_tdata[3:0];
	assign in_delay   = s_axis_tdata[34:4];
	assign in_handler = s_axis_tdata[42:35];
	assign in_payload = s_axis_tdata[74:43];
	assign in_range   = (32'(in_id) < 32'(SLOTS));
	assign in_slot    = IW'(in_id);
	assign in_acc     = s_axis_tvalid && s_axis_tready;
	assign t_sum      = SW'(tick_q) + SW'(in_delay);

	assign s_axis_tready = (state_q == stq_pkg::ST_IDLE);
	assign out_free      = !out_v_q || m_axis_tready;
	assign out_load      = ((state_q == stq_pkg::ST_TICK) && hold_v_q && out_free) ||
		((state_q == stq_pkg::ST_ACK) && out_free);

	assign rd_idx = (state_q == stq_pkg::ST_SCAN) ? at_pos : head;
	assign cmp_b  = (state_q == stq_pkg::ST_SCAN) ? t_q : tick_q;
	assign due    = (cnt != '0) && (k_q < KW'(stq_pkg::MAX_OUT)) && !later;

	stq_cmp #(.TIME_BITS(TIME_BITS)) u_cmp (
		.a     (expiry_q[rd_idx]),
		.b     (cmp_b),
		.later (later)
	);

	stq_list #(.SLOTS(SLOTS)) u_list (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (lop),
		.id     (slot_q),
		.pos    (pos_q),
		.head   (head),
		.at_pos (at_pos),
		.cnt    (cnt)
	);

	always_comb begin
		state_d = state_q;
		lop     = stq_pkg::LOP_NONE;
		case (state_q)
			stq_pkg::ST_IDLE: begin
				if (in_acc) begin
					case (in_cmd)
						stq_pkg::CMD_TICK: state_d = stq_pkg::ST_TICK;
						stq_pkg::CMD_ARM,
						stq_pkg::CMD_STOP: state_d = in_range ? stq_pkg::ST_DROP
							: stq_pkg::ST_ACK;
						default: state_d = stq_pkg::ST_IDLE;
					endcase
				end
			end
			stq_pkg::ST_TICK: begin
				if (!hold_v_q || out_free) begin
					if (due) begin
						lop = stq_pkg::LOP_POP;
					end else begin
						state_d = stq_pkg::ST_IDLE;
					end
				end
			end
			stq_pkg::ST_DROP: begin
				if (pending_q[slot_q]) begin
					lop = stq_pkg::LOP_DROP;
				end
				state_d = arm_q ? stq_pkg::ST_SCAN : stq_pkg::ST_ACK;
			end
			stq_pkg::ST_SCAN: begin
				if (pos_q >= cnt || later) begin
					lop     = stq_pkg::LOP_INSERT;
					state_d = stq_pkg::ST_ACK;
				end
			end
			stq_pkg::ST_ACK: begin
				if (out_free) begin
					state_d = stq_pkg::ST_IDLE;
				end
			end
			default: state_d = stq_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= stq_pkg::ST_IDLE;
			tick_q    <= '0;
			pending_q <= '0;
			hold_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
			k_q       <= '0;
			pos_q     <= '0;
			arm_q     <= 1'b0;
			hc_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				stq_pkg::ST_IDLE: begin
					if (in_acc) begin
						arm_q <= (in_cmd == stq_pkg::CMD_ARM);
						pos_q <= '0;
						k_q   <= '0;
						hc_q  <= 1'b0;
						if (in_cmd == stq_pkg::CMD_TICK) begin
							tick_q <= tick_q + 1'b1;
						end
					end
				end
				stq_pkg::ST_TICK: begin
					if (!hold_v_q || out_free) begin
						hold_v_q <= due;
						if (due) begin
							pending_q[head] <= 1'b0;
							k_q <= k_q + 1'b1;
						end
					end
				end
				stq_pkg::ST_DROP: begin
					pending_q[slot_q] <= 1'b0;
					hc_q <= was_head_q;
				end
				stq_pkg::ST_SCAN: begin
					if (pos_q >= cnt || later) begin
						pending_q[slot_q] <= 1'b1;
						hc_q <= was_head_q || (pos_q == '0);
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_cmd == stq_pkg::CMD_ARM && in_range) begin
			expiry_q[in_slot]  <= t_sum[TIME_BITS-1:0];
			handler_q[in_slot] <= in_handler;
			payload_q[in_slot] <= in_payload;
		end
		if (in_acc) begin
			slot_q     <= in_slot;
			t_q        <= t_sum[TIME_BITS-1:0];
			was_head_q <= in_range && (cnt != '0) && (head == in_slot) && pending_q[in_slot];
		end
		if (state_q == stq_pkg::ST_TICK && (!hold_v_q || out_free)) begin
			if (due) begin
				hold_id_q      <= head;
				hold_handler_q <= handler_q[head];
				hold_payload_q <= payload_q[head];
			end
			if (hold_v_q) begin
				out_kind_q    <= 1'b1;
				out_hc_q      <= 1'b0;
				out_id_q      <= 4'(hold_id_q);
				out_handler_q <= hold_handler_q;
				out_payload_q <= hold_payload_q;
				out_last_q    <= !due;
			end
		end
		if (state_q == stq_pkg::ST_ACK && out_free) begin
			out_kind_q    <= 1'b0;
			out_hc_q      <= hc_q;
			out_id_q      <= '0;
			out_handler_q <= '0;
			out_payload_q <= '0;
			out_last_q    <= 1'b1;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {3'b000, out_payload_q, out_handler_q, out_id_q, out_hc_q};

	a_list_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == stq_pkg::ST_IDLE) |-> ($countones(pending_q) == 32'(cnt)))
		else $error("pending set and list length disagree");

	a_tick_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_cmd == stq_pkg::CMD_TICK) |=> (tick_q == $past(tick_q) + 1'b1))
		else $error("tick count did not advance");

	a_ack_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
		else $error("acknowledge without last");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != stq_pkg::ST_IDLE) |-> !s_axis_tready)
		else $error("ready while a command is in progress");

endmodule

`default_nettype wire
